// ===== rtl/core/dreq_pkg.sv =====
// ----------------------------------------------------------------------------
// dreq_pkg: shared types and constants for the disk request elevator queue
// Partition table, result kinds and controller/datapath command bundle.
// ----------------------------------------------------------------------------
package dreq_pkg;

  localparam int QDEPTH   = 16;
  localparam int QW       = $clog2(QDEPTH);
  localparam int NUNITS   = 2;
  localparam int CYLW     = 10;
  localparam logic [3:0] RETRY_RST = 4'd10;

  typedef enum logic [2:0] {
    KIND_REJECT  = 3'd0,
    KIND_START   = 3'd1,
    KIND_DONE    = 3'd2,
    KIND_RECOVER = 3'd3,
    KIND_FULL    = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0]      tag;
    logic            unit;
    logic [CYLW-1:0] cyl;
    logic [2:0]      trk;
    logic [4:0]      sec;
    logic            wr;
  } entry_t;

  // datapath commands issued by the controller
  typedef struct packed {
    logic latch_in;   // capture input item, compute geometry
    logic alloc;      // write new entry at free slot
    logic walk_init;  // p1 <= head, start walk
    logic walk_rd;    // issue link/entry read of p1
    logic walk_step;  // evaluate, advance p1
    logic link_a;     // link new <- link[p1]
    logic link_b;     // link[p1] <- new
    logic set_head;   // head <- new slot (queue was empty)
    logic remove;     // free head, advance head
    logic rd_head;    // read head entry
    logic inc_err;
    logic clr_err;
    logic set_busy;
    logic clr_busy;
  } cmd_t;

  typedef struct packed {
    logic bad;        // out of range
    logic full;
    logic nonempty;
    logic busy;
    logic walk_hit;   // insertion point found or walk ended
    logic rd_ok;      // walk data ready
    logic retry_ok;   // error_count+1 <= limit
    logic last_entry; // entry_count == 1
  } sts_t;

  function automatic logic [16:0] part_blocks(input logic [2:0] p);
    case (p)
      3'd4, 3'd6: part_blocks = 17'd65535;
      3'd5:       part_blocks = 17'd160;
      3'd7:       part_blocks = 17'd480;
      default:    part_blocks = 17'd32800;
    endcase
  endfunction

  function automatic logic [CYLW-1:0] part_cyl(input logic [2:0] p);
    case (p)
      3'd1:    part_cyl = 10'd205;
      3'd2:    part_cyl = 10'd410;
      3'd3:    part_cyl = 10'd615;
      3'd5:    part_cyl = 10'd409;
      3'd6:    part_cyl = 10'd410;
      3'd7:    part_cyl = 10'd819;
      default: part_cyl = 10'd0;
    endcase
  endfunction

endpackage

// ===== rtl/core/disk_request_elevator_queue_top.sv =====
// ----------------------------------------------------------------------------
// disk_request_elevator_queue_top: elevator-ordered disk request queue
// Range check, geometry, linked queue insert, retry and completion handling.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with the in_* fields while busy is low; the item is taken at
//   that edge. in_cmd 0 submits a request, 1 reports a finished transfer.
//   Results appear as single-cycle beats with out_valid high;
//   out_last marks the final beat of an item. The receiver cannot stall.
//   cfg_valid/cfg_ready write retry_limit (reset 10); ready is always high,
//   write only while busy is low.
// Timing:
//   Every beat is registered, in the cycle after the controller step that
//   makes it. A reject, a full queue or an idle completion ends at decode.
//   A submit is allocated and, into a nonempty queue, walked to its elevator
//   place and linked; the head is then started when idle. A retried completion
//   runs head read and start; a finished one runs done and remove, then
//   starts any next head. At most three result beats per item.
// Reset: synchronous active-low rst_n empties the queue and clears busy;
//   the request and link memories are not cleared.
// ----------------------------------------------------------------------------
module disk_request_elevator_queue_top import dreq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_cmd,
  input  logic [7:0]  in_minor_dev,
  input  logic [15:0] in_block_num,
  input  logic [7:0]  in_req_tag,
  input  logic        in_is_write,
  input  logic        in_comp_error,
  input  logic        in_drive_fault,
  input  logic        in_vol_valid,
  input  logic [15:0] in_words_left,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_retry_limit,
  output logic        out_valid,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_tag_out,
  output logic        out_unit,
  output logic [9:0]  out_cylinder,
  output logic [2:0]  out_track,
  output logic [4:0]  out_sector,
  output logic        out_write_out,
  output logic [1:0]  out_recovery,
  output logic        out_failed,
  output logic [15:0] out_residual,
  output logic        out_last
);
  cmd_t        cmd;
  sts_t        sts;
  entry_t      head_e, new_e;
  logic        cmd_r, cerr_r;
  logic [1:0]  rec_r;
  logic [15:0] words_r;
  logic [3:0]  limit_r;
  kind_t       rkind;
  logic        rvalid, rlast, rfailed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n)                      limit_r <= RETRY_RST;
    else if (cfg_valid && cfg_ready) limit_r <= cfg_retry_limit;
  end

  dreq_dp u_dp (
    .clk, .rst_n, .in_cmd, .in_minor_dev, .in_block_num, .in_req_tag,
    .in_is_write, .in_comp_error, .in_drive_fault, .in_vol_valid,
    .in_words_left, .retry_limit(limit_r), .cmd, .sts,
    .head_entry(head_e), .new_entry(new_e), .cmd_r,
    .comp_error_r(cerr_r), .rec_r, .words_r);

  dreq_ctrl u_ctrl (
    .clk, .rst_n, .start, .busy, .sts, .cmd_r, .comp_error_r(cerr_r),
    .cmd, .rkind, .rvalid, .rlast, .rfailed);

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= rvalid;
    end
    out_kind      <= rkind;
    out_last      <= rlast;
    out_tag_out   <= (rkind == KIND_REJECT || rkind == KIND_FULL) ? new_e.tag
                                                                  : head_e.tag;
    out_unit      <= (rkind == KIND_START) ? head_e.unit : 1'b0;
    out_cylinder  <= (rkind == KIND_START) ? head_e.cyl : '0;
    out_track     <= (rkind == KIND_START) ? head_e.trk : '0;
    out_sector    <= (rkind == KIND_START) ? head_e.sec : '0;
    out_write_out <= (rkind == KIND_START) ? head_e.wr : 1'b0;
    out_recovery  <= (rkind == KIND_RECOVER) ? rec_r : 2'b0;
    out_failed    <= (rkind == KIND_DONE) ? rfailed : 1'b0;
    out_residual  <= (rkind == KIND_DONE) ? words_r : '0;
  end
endmodule

// ===== rtl/core/dreq_ram.sv =====
// ----------------------------------------------------------------------------
// dreq_ram: generic single-write RAM with registered read
// One write port, one read port, read data valid the cycle after the address.
// ----------------------------------------------------------------------------
module dreq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/dreq_dp.sv =====
// ----------------------------------------------------------------------------
// dreq_dp: datapath of the disk request queue
// Request and link memories, free map, head pointer and counters.
// ----------------------------------------------------------------------------
module dreq_dp import dreq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_cmd,
  input  logic [7:0]  in_minor_dev,
  input  logic [15:0] in_block_num,
  input  logic [7:0]  in_req_tag,
  input  logic        in_is_write,
  input  logic        in_comp_error,
  input  logic        in_drive_fault,
  input  logic        in_vol_valid,
  input  logic [15:0] in_words_left,
  input  logic [3:0]  retry_limit,
  input  cmd_t        cmd,
  output sts_t        sts,
  output entry_t      head_entry,
  output entry_t      new_entry,
  output logic        cmd_r,
  output logic        comp_error_r,
  output logic [1:0]  rec_r,
  output logic [15:0] words_r
);
  localparam int CW = $clog2(QDEPTH + 1);

  logic [QDEPTH-1:0] free_r, free_nxt;
  logic [QW-1:0]     head_r, slot_r, p1_r, p2_r;
  logic              nonempty_r, busy_r;
  logic [3:0]        err_r;
  logic [CW-1:0]     count_r, walk_i_r;
  logic              bad_r;
  entry_t            new_r;

  // memories: entry store read at one address, link store read at one
  logic              e_we, l_we;
  logic [QW-1:0]     e_raddr, l_waddr, l_raddr;
  entry_t            e_rdata;
  logic [QW-1:0]     l_wdata, l_rdata;

  // walk holds the p1 cyl (a) while the p2 entry is read
  logic [CYLW-1:0]   a_r;
  logic [1:0]        wph_r;

  // geometry: blk/160 = (blk>>5)/5 ; q=blk>>5 (11 bits), q/5 via reciprocal
  logic [10:0] q;
  logic [22:0] qm;
  logic [8:0]  q5;
  logic [10:0] r5;
  logic [QW-1:0] first_free;

  assign q  = in_block_num[15:5];
  assign qm = 23'(q) * 23'd3277;
  assign q5 = 9'(qm >> 14);
  assign r5 = q - 11'(11'(q5) * 11'd5);

  always_comb begin
    first_free = '0;
    for (int i = QDEPTH - 1; i >= 0; i--) if (free_r[i]) first_free = QW'(i);
  end

  dreq_ram #(.WIDTH($bits(entry_t)), .DEPTH(QDEPTH)) u_ent (
    .clk, .we(e_we), .waddr(slot_r), .wdata(new_r),
    .raddr(e_raddr), .rdata(e_rdata));
  dreq_ram #(.WIDTH(QW), .DEPTH(QDEPTH)) u_lnk (
    .clk, .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata));

  assign e_we = cmd.alloc;
  // link_a writes link[new] <= link[p1] (read data), link_b writes link[p1] <= new
  assign l_we    = cmd.link_a | cmd.link_b;
  assign l_waddr = cmd.link_a ? slot_r : p1_r;
  assign l_wdata = cmd.link_a ? l_rdata : slot_r;
  // a completion reads the head's link ahead of the remove step
  assign l_raddr = cmd_r ? head_r : p1_r;
  // phase 0 reads p1 entry, phase 1 reads p2 entry; rd_head reads head
  assign e_raddr = (cmd.walk_rd && wph_r == 2'd1) ? l_rdata :
                   (cmd.walk_rd ? p1_r : head_r);

  assign head_entry = e_rdata;
  assign new_entry  = new_r;

  logic hit;
  assign hit = (a_r <= new_r.cyl && new_r.cyl < e_rdata.cyl) ||
               (a_r >= new_r.cyl && new_r.cyl > e_rdata.cyl);

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_r        <= in_cmd;
      comp_error_r <= in_comp_error;
      rec_r        <= {~in_vol_valid, in_drive_fault};
      words_r      <= in_words_left;
      bad_r        <= (in_minor_dev >= 8'(NUNITS << 3)) ||
                      ({1'b0, in_block_num} >= part_blocks(in_minor_dev[2:0]));
      new_r.tag    <= in_req_tag;
      new_r.unit   <= in_minor_dev[3];
      new_r.cyl    <= part_cyl(in_minor_dev[2:0]) + CYLW'(q5) ;
      new_r.trk    <= 3'(r5);
      new_r.sec    <= in_block_num[4:0];
      new_r.wr     <= in_is_write;
      slot_r       <= first_free;
    end
    if (cmd.walk_rd) begin
      if (wph_r == 2'd0) begin
        wph_r <= 2'd1;
      end else if (wph_r == 2'd1) begin
        wph_r <= 2'd2;
        p2_r  <= l_rdata;
      end
    end
    if (cmd.walk_init) begin
      wph_r <= 2'd0;
    end
    if (cmd.walk_step) begin
      wph_r <= 2'd0;
    end
    if (cmd.walk_rd && wph_r == 2'd1) a_r <= e_rdata.cyl;
  end

  always_comb begin
    free_nxt = free_r;
    if (cmd.alloc)  free_nxt[slot_r] = 1'b0;
    if (cmd.remove) free_nxt[head_r] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r     <= '1;
      head_r     <= '0;
      nonempty_r <= 1'b0;
      busy_r     <= 1'b0;
      err_r      <= '0;
      count_r    <= '0;
      walk_i_r   <= '0;
      p1_r       <= '0;
    end else begin
      free_r <= free_nxt;
      if (cmd.alloc) count_r <= count_r + 1'b1;
      if (cmd.set_head) begin
        head_r     <= slot_r;
        nonempty_r <= 1'b1;
      end
      if (cmd.walk_init) begin
        p1_r     <= head_r;
        walk_i_r <= CW'(1);
      end
      if (cmd.walk_step && !hit) begin
        p1_r     <= p2_r;
        walk_i_r <= walk_i_r + 1'b1;
      end
      if (cmd.remove) begin
        count_r <= count_r - 1'b1;
        if (count_r == CW'(1)) nonempty_r <= 1'b0;
        else                   head_r <= l_rdata;
      end
      if (cmd.inc_err)  err_r  <= err_r + 1'b1;
      if (cmd.clr_err)  err_r  <= '0;
      if (cmd.set_busy) busy_r <= 1'b1;
      if (cmd.clr_busy) busy_r <= 1'b0;
    end
  end

  always_comb begin
    sts.bad        = bad_r;
    sts.full       = (count_r >= CW'(QDEPTH));
    sts.nonempty   = nonempty_r;
    sts.busy       = busy_r;
    // walk ends when i reaches count (before this entry was added)
    sts.walk_hit   = ((walk_i_r + CW'(1)) >= count_r) || (wph_r == 2'd2 && hit);
    sts.rd_ok      = (wph_r == 2'd2);
    sts.retry_ok   = ({1'b0, err_r} + 5'd1) <= {1'b0, retry_limit};
    sts.last_entry = (count_r == CW'(1));
  end
endmodule

// ===== rtl/core/dreq_ctrl.sv =====
// ----------------------------------------------------------------------------
// dreq_ctrl: sequencer of the disk request queue
// Steps through check, allocation, elevator walk, linking, removal and result beats.
// ----------------------------------------------------------------------------
module dreq_ctrl import dreq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  sts_t        sts,
  input  logic        cmd_r,
  input  logic        comp_error_r,
  output cmd_t        cmd,
  output kind_t       rkind,
  output logic        rvalid,
  output logic        rlast,
  output logic        rfailed
);
  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_DECODE  = 11'b00000000010,
    S_ALLOC   = 11'b00000000100,
    S_WRD     = 11'b00000001000,
    S_WSTEP   = 11'b00000010000,
    S_LINKA   = 11'b00000100000,
    S_LINKB   = 11'b00001000000,
    S_HEADRD  = 11'b00010000000,
    S_START   = 11'b00100000000,
    S_DONE    = 11'b01000000000,
    S_REMOVE  = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   fail_r, fail_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    fail_nxt  = fail_r;
    cmd       = '0;
    rvalid    = 1'b0;
    rkind     = KIND_REJECT;
    rlast     = 1'b0;
    rfailed   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.rd_head = 1'b1;
        if (!cmd_r) begin
          if (sts.bad || sts.full) begin
            rvalid    = 1'b1;
            rlast     = 1'b1;
            rkind     = sts.bad ? KIND_REJECT : KIND_FULL;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_ALLOC;
          end
        end else if (!sts.busy) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.clr_busy = 1'b1;
          if (comp_error_r) begin
            rvalid = 1'b1;
            rkind  = KIND_RECOVER;
            if (sts.retry_ok) begin
              cmd.inc_err = 1'b1;
              state_nxt   = S_HEADRD;
            end else begin
              fail_nxt  = 1'b1;
              state_nxt = S_DONE;
            end
          end else begin
            fail_nxt  = 1'b0;
            state_nxt = S_DONE;
          end
        end
      end
      S_ALLOC: begin
        cmd.alloc = 1'b1;
        if (!sts.nonempty) begin
          cmd.set_head = 1'b1;
          state_nxt    = sts.busy ? S_IDLE : S_HEADRD;
        end else begin
          cmd.walk_init = 1'b1;
          state_nxt     = S_WRD;
        end
      end
      S_WRD: begin
        if (sts.walk_hit) begin
          state_nxt = S_LINKA;
        end else begin
          cmd.walk_rd = 1'b1;
          if (sts.rd_ok) state_nxt = S_WSTEP;
        end
      end
      S_WSTEP: begin
        cmd.walk_step = 1'b1;
        state_nxt     = S_WRD;
        if (sts.walk_hit) state_nxt = S_LINKA;
      end
      S_LINKA: begin
        // link read of p1 issued here (raddr = p1), data next cycle
        state_nxt = S_LINKB;
      end
      S_LINKB: begin
        cmd.link_a = 1'b1;
        state_nxt  = S_REMOVE;
      end
      S_REMOVE: begin
        if (cmd_r) begin
          cmd.remove = 1'b1;
          state_nxt  = sts.last_entry ? S_IDLE : S_HEADRD;
        end else begin
          cmd.link_b = 1'b1;
          state_nxt  = sts.busy ? S_IDLE : S_HEADRD;
        end
      end
      S_HEADRD: begin
        cmd.rd_head = 1'b1;
        state_nxt   = S_START;
      end
      S_START: begin
        cmd.set_busy = 1'b1;
        rvalid       = 1'b1;
        rkind        = KIND_START;
        rlast        = 1'b1;
        state_nxt    = S_IDLE;
      end
      S_DONE: begin
        cmd.clr_err = 1'b1;
        rvalid      = 1'b1;
        rkind       = KIND_DONE;
        rfailed     = fail_r;
        rlast       = sts.last_entry;
        state_nxt   = S_REMOVE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fail_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fail_r  <= fail_nxt;
    end
  end
endmodule

// ===== rtl/core/dreq_chk.sv =====
// ----------------------------------------------------------------------------
// dreq_chk: port checker for the disk request queue
// Watches start/busy and the result strobe at the top level.
// ----------------------------------------------------------------------------
module dreq_chk import dreq_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [2:0] out_kind,
  input logic       out_last
);
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted item did not raise busy");
  a_kind_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind <= KIND_FULL) else $error("bad result kind");
  a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_REJECT || out_kind == KIND_FULL) |-> out_last)
    else $error("reject not final beat");
endmodule

bind disk_request_elevator_queue_top dreq_chk u_chk (
  .clk, .rst_n, .start, .busy, .out_valid, .out_kind, .out_last);
